>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check, clocked on the rising edge, off while in reset.
`define ETOK_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("etok assertion failed");

// Overlapping implication check built on the general form.
`define ETOK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`ETOK_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

>>> hw/rtl/etok_pkg.sv
// Package: character codes, token kinds and queue types of the tokenizer.
`default_nettype none
package etok_pkg;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// token kinds
	localparam logic [3:0] KIND_NUMBER = 4'd0;
	localparam logic [3:0] KIND_IDENT  = 4'd1;
	localparam logic [3:0] KIND_PLUS   = 4'd2;
	localparam logic [3:0] KIND_MINUS  = 4'd3;
	localparam logic [3:0] KIND_STAR   = 4'd4;
	localparam logic [3:0] KIND_SLASH  = 4'd5;
	localparam logic [3:0] KIND_CARET  = 4'd6;
	localparam logic [3:0] KIND_OPEN   = 4'd7;
	localparam logic [3:0] KIND_CLOSE  = 4'd8;
	localparam logic [3:0] KIND_ERROR  = 4'd9;
	localparam logic [3:0] KIND_END    = 4'd10;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
		logic       tlast;
	} lex_res_t;

	// results of one byte: one, or two when pair is set
	typedef struct packed {
		lex_res_t first;
		lex_res_t second;
		logic     pair;
	} lex_entry_t;

	typedef struct packed {
		logic       push;
		lex_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic       avail;
		lex_entry_t entry;
	} q_head_t;

endpackage
`default_nettype wire

>>> hw/rtl/etok_if.sv
// Valid/ready channel interfaces for text bytes and token results.
`default_nettype none
interface etok_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface etok_tok_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] lexeme_char;
	logic       token_last;
	logic       run_last;

	modport source (output valid, output token_kind, output lexeme_char,
		output token_last, output run_last, input ready);
	modport sink (input valid, input token_kind, input lexeme_char,
		input token_last, input run_last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/expression_tokenizer_core.sv
// Top level of the streaming expression tokenizer.
//
//  channel   dir  payload                                        handshake
//  text      in   text_byte[7:0]                                 valid/ready
//  tokens    out  token_kind[3:0] lexeme_char[7:0]               valid/ready
//                 token_last run_last
//
// One text byte is taken per clock while the result queue has room; the
// lexing mode and held character live in the front, updated on each taken byte.
// A byte's results enter the queue when it is taken and pass the output register;
// one result leaves a clock while tokens.ready is high; a pair goes out in turn.
// arst_n clears mode, held character, queue pointers and output valid.
// Output stalls back up through the 4-group queue to text.ready.
`default_nettype none
module expression_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	etok_byte_if.sink   text,
	etok_tok_if.source  tokens
);
	import etok_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;

	// front: classify byte, update mode, group results
	etok_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_byte  (text.text_byte),
		.in_ready (text.ready),
		.q_full   (q_full),
		.push     (push)
	);

	// queue decouples the two sides
	etok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// back: one result per item on the output channel
	etok_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (tokens.valid),
		.out_ready   (tokens.ready),
		.token_kind  (tokens.token_kind),
		.lexeme_char (tokens.lexeme_char),
		.token_last  (tokens.token_last),
		.run_last    (tokens.run_last)
	);

endmodule
`default_nettype wire

>>> hw/rtl/etok_front.sv
// Front end: lexing mode, held character and result grouping per byte.
`default_nettype none
module etok_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	output logic              in_ready,
	input  logic              q_full,
	output etok_pkg::q_push_t push
);
	import etok_pkg::*;

	typedef enum logic [7:0] {
		M_IDLE   = 8'b0000_0001,
		M_SINGLE = 8'b0000_0010,
		M_STAR   = 8'b0000_0100,
		M_INT    = 8'b0000_1000,
		M_FRAC   = 8'b0001_0000,
		M_EXPS   = 8'b0010_0000,
		M_EXPD   = 8'b0100_0000,
		M_IDENT  = 8'b1000_0000
	} mode_t;

	mode_t      mode_q, n_mode, cont_mode, st_mode;
	logic [7:0] held_char_q, n_char;
	logic [3:0] held_kind_q, n_kind, st_kind;
	logic       fire, is_digit, is_letter, is_space, is_e, active, push_v;
	lex_entry_t ent;
	lex_res_t   flush_res, end_res;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;

	assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_letter = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
		((in_byte >= 8'h41) && (in_byte <= 8'h5A));
	assign is_space  = (in_byte == 8'h20) || ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
	assign is_e      = (in_byte == CH_E_LO) || (in_byte == CH_E_UP);
	assign active    = (mode_q != M_IDLE);

	// does the byte extend the held token?
	always_comb begin
		cont_mode = M_IDLE;
		unique case (mode_q)
			M_INT: begin
				if (is_digit)                 cont_mode = M_INT;
				else if (in_byte == CH_DOT)   cont_mode = M_FRAC;
				else if (is_e)                cont_mode = M_EXPS;
			end
			M_FRAC: begin
				if (is_digit)   cont_mode = M_FRAC;
				else if (is_e)  cont_mode = M_EXPS;
			end
			M_EXPS: begin
				if (is_digit || in_byte == CH_PLUS || in_byte == CH_MINUS)
					cont_mode = M_EXPD;
			end
			M_EXPD: begin
				if (is_digit) cont_mode = M_EXPD;
			end
			M_IDENT: begin
				if (is_letter || is_digit) cont_mode = M_IDENT;
			end
			default: cont_mode = M_IDLE;
		endcase
	end

	// token started by this byte when it does not extend the held one
	always_comb begin
		st_kind = KIND_ERROR;
		st_mode = M_SINGLE;
		unique case (in_byte)
			CH_PLUS:  st_kind = KIND_PLUS;
			CH_MINUS: st_kind = KIND_MINUS;
			CH_STAR: begin
				st_kind = KIND_STAR;
				st_mode = M_STAR;
			end
			CH_SLASH: st_kind = KIND_SLASH;
			CH_CARET: st_kind = KIND_CARET;
			CH_OPEN:  st_kind = KIND_OPEN;
			CH_CLOSE: st_kind = KIND_CLOSE;
			default: begin
				if (is_digit) begin
					st_kind = KIND_NUMBER;
					st_mode = M_INT;
				end else if (is_letter) begin
					st_kind = KIND_IDENT;
					st_mode = M_IDENT;
				end
			end
		endcase
	end

	always_comb begin
		flush_res.kind  = held_kind_q;
		flush_res.ch    = held_char_q;
		flush_res.tlast = 1'b1;
		end_res.kind    = KIND_END;
		end_res.ch      = CH_NUL;
		end_res.tlast   = 1'b1;

		n_mode = mode_q;
		n_char = held_char_q;
		n_kind = held_kind_q;
		ent    = '0;
		push_v = 1'b0;

		if (mode_q == M_STAR && in_byte == CH_STAR) begin
			// doubled star folds into one caret, nothing leaves yet
			n_char = CH_CARET;
			n_kind = KIND_CARET;
			n_mode = M_SINGLE;
		end else if (cont_mode != M_IDLE) begin
			ent.first.kind  = held_kind_q;
			ent.first.ch    = held_char_q;
			ent.first.tlast = 1'b0;
			push_v = 1'b1;
			n_char = in_byte;
			n_mode = cont_mode;
		end else if (in_byte == CH_NUL) begin
			push_v = 1'b1;
			n_mode = M_IDLE;
			n_char = '0;
			n_kind = '0;
			if (active) begin
				ent.first  = flush_res;
				ent.second = end_res;
				ent.pair   = 1'b1;
			end else begin
				ent.first  = end_res;
			end
		end else if (is_space) begin
			push_v    = active;
			ent.first = flush_res;
			n_mode    = M_IDLE;
		end else begin
			push_v    = active;
			ent.first = flush_res;
			n_char    = in_byte;
			n_kind    = st_kind;
			n_mode    = st_mode;
		end
	end

	assign push.push  = fire && push_v;
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			held_char_q <= '0;
			held_kind_q <= '0;
		end else if (fire) begin
			mode_q      <= n_mode;
			held_char_q <= n_char;
			held_kind_q <= n_kind;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/etok_queue.sv
// Short queue of per-byte result groups between front and back.
`default_nettype none
module etok_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  etok_pkg::q_push_t push,
	output logic              full,
	output etok_pkg::q_head_t head,
	input  logic              pop
);
	import etok_pkg::*;

	lex_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     cnt_q;
	logic             do_push, do_pop;

	assign full       = (cnt_q == QDEPTH[QAW:0]);
	assign head.avail = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.entry;
	end

endmodule
`default_nettype wire

>>> hw/rtl/etok_back.sv
// Back end: splits result groups into single items behind an output register.
`default_nettype none
module etok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  etok_pkg::q_head_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        token_kind,
	output logic [7:0]        lexeme_char,
	output logic              token_last,
	output logic              run_last
);
	import etok_pkg::*;

	logic     oval_q, sel_q, orl_q, load, last_of_grp;
	lex_res_t ores_q, cur;

	assign cur         = sel_q ? head.entry.second : head.entry.first;
	assign last_of_grp = sel_q || !head.entry.pair;
	assign load        = head.avail && (!oval_q || out_ready);
	assign pop         = load && last_of_grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			sel_q  <= 1'b0;
		end else if (load) begin
			oval_q <= 1'b1;
			sel_q  <= !last_of_grp;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ores_q <= cur;
			orl_q  <= last_of_grp;
		end
	end

	assign out_valid   = oval_q;
	assign token_kind  = ores_q.kind;
	assign lexeme_char = ores_q.ch;
	assign token_last  = ores_q.tlast;
	assign run_last    = orl_q;

endmodule
`default_nettype wire

>>> hw/rtl/etok_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module etok_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] token_kind,
	input logic [7:0] lexeme_char,
	input logic       token_last,
	input logic       run_last
);
	import etok_pkg::*;

	// stalled item holds
	`ETOK_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(lexeme_char) && $stable(token_last) && $stable(run_last))

	// end token is a lone zero character closing its byte
	`ETOK_ASSERT_IMPL(a_end_form, clk, arst_n, out_valid && token_kind == KIND_END, token_last && run_last && lexeme_char == CH_NUL)

	// the earlier of two results always closes a token
	`ETOK_ASSERT_IMPL(a_pair_first, clk, arst_n, out_valid && !run_last, token_last)

	// second result of a byte follows in the next cycle
	`ETOK_ASSERT(a_pair_next, clk, arst_n, out_valid && out_ready && !run_last |=> out_valid)

	// caret tokens carry a caret, also when folded from a doubled star
	`ETOK_ASSERT_IMPL(a_caret, clk, arst_n, out_valid && token_kind == KIND_CARET, lexeme_char == CH_CARET)

endmodule

bind expression_tokenizer_core etok_checker u_etok_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.token_kind  (tokens.token_kind),
	.lexeme_char (tokens.lexeme_char),
	.token_last  (tokens.token_last),
	.run_last    (tokens.run_last)
);
`default_nettype wire
